// File: src/fcw_pkg.sv
package fcw_pkg;

   // Field widths of the request and response items
   localparam int ENTRY_W   = 12;
   localparam int BYTE_W    = 8;
   localparam int LOAD_AW   = 13;
   localparam int LBA_W     = 32;
   localparam int SPC_W     = 8;
   localparam int RUN_W     = 7;
   localparam int PROD_W    = ENTRY_W + SPC_W;
   localparam int CSR_IDX_W = 2;

   // FAT12 entry at or above this value ends a chain
   localparam logic [ENTRY_W-1:0] END_MARK = 12'hFF8;

   // Request kinds
   localparam logic REQ_LOAD = 1'b0;
   localparam logic REQ_WALK = 1'b1;

   // Register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_DATA_BASE = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_SPC       = 2'd1;

   // Walk sequencer
   typedef enum logic [1:0] {
      S_IDLE,
      S_RD_LO,
      S_RD_HI,
      S_EMIT
   } walk_state_type;

endpackage

// File: src/fcw_ram.sv
module fcw_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 8192
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   // Registered read port, holds when not enabled
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// File: src/fat12_cluster_chain_walker.sv
// Load request: writes one table byte, no response.
// Walk request: each response takes two reads of the single table RAM port (S_RD_LO, S_RD_HI)
// and an S_EMIT step that forms the entry and waits while the output is stalled; up to MAX_RUN responses.
// The first response passes S_RD_LO, S_RD_HI and S_EMIT into the output register; a new request is taken once
// the last response is loaded into the output register.
// Reset: synchronous, active high; clears sequencer, output valid and registers
// (data_area_base 0, sectors_per_cluster 1); table contents are undefined until loaded.
module fat12_cluster_chain_walker #(
   parameter int TABLE_BYTES = 8192,
   parameter int MAX_RUN     = 64
) (
   input  logic                           clock,
   input  logic                           reset,
   // Request channel
   input  logic                           req_valid,
   output logic                           req_stall,
   input  logic                           req_type,
   input  logic [fcw_pkg::LOAD_AW-1:0]    req_table_addr,
   input  logic [fcw_pkg::BYTE_W-1:0]     req_table_byte,
   input  logic [fcw_pkg::ENTRY_W-1:0]    req_start_cluster,
   // Response channel
   output logic                           rsp_valid,
   input  logic                           rsp_stall,
   output logic [fcw_pkg::ENTRY_W-1:0]    rsp_cluster,
   output logic [fcw_pkg::LBA_W-1:0]      rsp_sector_lba,
   output logic [fcw_pkg::ENTRY_W-1:0]    rsp_next_cluster,
   output logic                           rsp_chain_end,
   output logic                           rsp_last,
   // Register write channel
   input  logic                           csr_valid,
   output logic                           csr_ready,
   input  logic [fcw_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [fcw_pkg::LBA_W-1:0]      csr_wdata
);

   import fcw_pkg::*;

   localparam int AW    = $clog2(TABLE_BYTES);
   localparam int IDX_W = ENTRY_W + 2;
   localparam int MOD_W = 21;

   // Reduce a byte index modulo the table size (quotient is below 16)
   function automatic logic [AW-1:0] wrap_addr(input logic [IDX_W-1:0] a);
      logic [MOD_W-1:0] v;
      logic [MOD_W-1:0] step;
      v = MOD_W'(a);
      for (int k = 3; k >= 0; k--) begin
         step = MOD_W'(TABLE_BYTES) << k;
         if (v >= step) begin
            v = v - step;
         end
      end
      return v[AW-1:0];
   endfunction

   walk_state_type state_ff, state_in;

   logic [ENTRY_W-1:0] cluster_ff, cluster_in;
   logic [RUN_W-1:0]   run_ff, run_in;
   logic [BYTE_W-1:0]  lo_ff;
   logic [PROD_W-1:0]  prod_ff, prod_in;
   logic [LBA_W-1:0]   base_ff, base_in;
   logic [SPC_W-1:0]   spc_ff, spc_in;

   logic               rsp_valid_ff, rsp_valid_in;
   logic [ENTRY_W-1:0] rsp_cluster_ff;
   logic [LBA_W-1:0]   rsp_lba_ff;
   logic [ENTRY_W-1:0] rsp_next_ff;
   logic               rsp_end_ff;
   logic               rsp_last_ff;

   logic               req_take;
   logic               walk_take;
   logic               load_take;
   logic               out_free;
   logic               emit_go;
   logic               ram_rd_en;
   logic [AW-1:0]      ram_rd_addr;
   logic [BYTE_W-1:0]  ram_rd_data;
   logic [IDX_W-1:0]   entry_idx;
   logic [2*BYTE_W-1:0] pair;
   logic [ENTRY_W-1:0] next_entry;
   logic               is_end;
   logic [RUN_W-1:0]   run_plus;
   logic               is_fin;
   logic [LBA_W-1:0]   lba;

   // Allocation table
   fcw_ram #(
      .WIDTH(BYTE_W),
      .DEPTH(TABLE_BYTES)
   ) u_table (
      .clock   (clock),
      .wr_en   (load_take),
      .wr_addr (wrap_addr(IDX_W'(req_table_addr))),
      .wr_data (req_table_byte),
      .rd_en   (ram_rd_en),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

   // Request handshake
   assign req_take  = req_valid && !req_stall;
   assign walk_take = req_take && (req_type == REQ_WALK);
   assign load_take = req_take && (req_type == REQ_LOAD);
   assign out_free  = !rsp_valid_ff || !rsp_stall;

   // Entry decode: byte index is cluster*3/2, pair is little endian
   assign entry_idx  = IDX_W'(cluster_ff) + IDX_W'(cluster_ff >> 1);
   assign pair       = {ram_rd_data, lo_ff};
   assign next_entry = cluster_ff[0] ? pair[15:4] : pair[11:0];
   assign is_end     = next_entry >= END_MARK;
   assign run_plus   = run_ff + RUN_W'(1);
   assign is_fin     = is_end || (run_plus >= RUN_W'(MAX_RUN));

   // Sector address: base + cluster*spc - 2*spc, all mod 2^32
   assign prod_in = PROD_W'(cluster_ff) * PROD_W'(spc_ff);
   assign lba     = base_ff + LBA_W'(prod_ff) - LBA_W'({spc_ff, 1'b0});

   // Next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         S_IDLE: begin
            if (walk_take) begin
               state_in = S_RD_LO;
            end
         end
         S_RD_LO: state_in = S_RD_HI;
         S_RD_HI: state_in = S_EMIT;
         S_EMIT: begin
            if (out_free) begin
               state_in = is_fin ? S_IDLE : S_RD_LO;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   // Sequencer outputs
   always_comb begin
      req_stall   = 1'b1;
      ram_rd_en   = 1'b0;
      ram_rd_addr = wrap_addr(entry_idx);
      emit_go     = 1'b0;
      case (state_ff)
         S_IDLE: req_stall = 1'b0;
         S_RD_LO: begin
            ram_rd_en   = 1'b1;
            ram_rd_addr = wrap_addr(entry_idx);
         end
         S_RD_HI: begin
            ram_rd_en   = 1'b1;
            ram_rd_addr = wrap_addr(entry_idx + IDX_W'(1));
         end
         S_EMIT: emit_go = out_free;
         default: req_stall = 1'b1;
      endcase
   end

   // Walk position and run count
   always_comb begin
      cluster_in = cluster_ff;
      run_in     = run_ff;
      if (walk_take) begin
         cluster_in = req_start_cluster;
         run_in     = '0;
      end else if (emit_go) begin
         cluster_in = next_entry;
         run_in     = run_plus;
      end
   end

   // Register writes; unknown indexes are dropped
   assign csr_ready = 1'b1;
   always_comb begin
      base_in = base_ff;
      spc_in  = spc_ff;
      if (csr_valid && csr_ready) begin
         if (csr_index == CSR_DATA_BASE) begin
            base_in = csr_wdata;
         end else if (csr_index == CSR_SPC) begin
            spc_in = csr_wdata[SPC_W-1:0];
         end
      end
   end

   // Output valid: set on emit, clear when taken
   assign rsp_valid_in = emit_go ? 1'b1 : (rsp_valid_ff && rsp_stall);

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         cluster_ff   <= '0;
         run_ff       <= '0;
         base_ff      <= '0;
         spc_ff       <= SPC_W'(1);
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cluster_ff   <= cluster_in;
         run_ff       <= run_in;
         base_ff      <= base_in;
         spc_ff       <= spc_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Hold the low byte and the product across the read cycles
   always_ff @(posedge clock) begin
      prod_ff <= prod_in;
      if (state_ff == S_RD_HI) begin
         lo_ff <= ram_rd_data;
      end
   end

   // Output payload
   always_ff @(posedge clock) begin
      if (emit_go) begin
         rsp_cluster_ff <= cluster_ff;
         rsp_lba_ff     <= lba;
         rsp_next_ff    <= next_entry;
         rsp_end_ff     <= is_end;
         rsp_last_ff    <= is_fin;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_cluster      = rsp_cluster_ff;
   assign rsp_sector_lba   = rsp_lba_ff;
   assign rsp_next_cluster = rsp_next_ff;
   assign rsp_chain_end    = rsp_end_ff;
   assign rsp_last         = rsp_last_ff;

endmodule

// File: sim/tb_top.sv
module tb_top;
   timeunit 1ns;
   timeprecision 1ps;

   import fcw_pkg::*;

   localparam int TABLE_SIZE    = 8192;
   localparam int RUN_LIMIT     = 64;
   localparam int LOAD_SETTLE   = 8;
   localparam int FINAL_SETTLE  = 200;
   localparam int LONG_HOLD     = 400;
   localparam int ITEM_TARGET   = 320;
   localparam int RANDOM_END    = 270;
   localparam int PHASE_ITEMS   = 45;
   localparam int LIMIT_CYCLES  = 2_000_000;

   // Register indexes past the end of the list; writes to them are dropped
   localparam logic [CSR_IDX_W-1:0] CSR_SPARE_LO = 2'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_SPARE_HI = 2'd3;

   typedef struct packed {
      logic [ENTRY_W-1:0] cluster;
      logic [LBA_W-1:0]   sector_lba;
      logic [ENTRY_W-1:0] next_cluster;
      logic               chain_end;
      logic               last;
   } chain_step_type;

   logic                 clock = 1'b0;
   logic                 reset = 1'b1;
   logic                 req_valid = 1'b0;
   logic                 req_stall;
   logic                 req_type = REQ_LOAD;
   logic [LOAD_AW-1:0]   req_table_addr = '0;
   logic [BYTE_W-1:0]    req_table_byte = '0;
   logic [ENTRY_W-1:0]   req_start_cluster = '0;
   logic                 rsp_valid;
   logic                 rsp_stall = 1'b0;
   logic [ENTRY_W-1:0]   rsp_cluster;
   logic [LBA_W-1:0]     rsp_sector_lba;
   logic [ENTRY_W-1:0]   rsp_next_cluster;
   logic                 rsp_chain_end;
   logic                 rsp_last;
   logic                 csr_valid = 1'b0;
   logic                 csr_ready;
   logic [CSR_IDX_W-1:0] csr_index = '0;
   logic [LBA_W-1:0]     csr_wdata = '0;

   // Mirror of the allocation table and of the registers
   bit [BYTE_W-1:0]      fat_mirror [TABLE_SIZE];
   bit                   byte_loaded [TABLE_SIZE];
   logic [LBA_W-1:0]     base_q = '0;
   logic [SPC_W-1:0]     spc_q = 8'd1;

   chain_step_type       chain_steps_due [$];
   logic [ENTRY_W-1:0]   chain_heads [$];

   int                   err_count = 0;
   int                   item_count = 0;
   int                   cycle_count = 0;
   int                   hold_total = 0;
   int                   hold_done = 0;
   int                   stall_left = 0;
   int                   flow_left = 0;
   bit                   quiet = 1'b0;

   fat12_cluster_chain_walker u_top (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_stall         (req_stall),
      .req_type          (req_type),
      .req_table_addr    (req_table_addr),
      .req_table_byte    (req_table_byte),
      .req_start_cluster (req_start_cluster),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_cluster       (rsp_cluster),
      .rsp_sector_lba    (rsp_sector_lba),
      .rsp_next_cluster  (rsp_next_cluster),
      .rsp_chain_end     (rsp_chain_end),
      .rsp_last          (rsp_last),
      .csr_valid         (csr_valid),
      .csr_ready         (csr_ready),
      .csr_index         (csr_index),
      .csr_wdata         (csr_wdata)
   );

   initial begin
      forever #4 clock = ~clock;
   end

   // Abort a hung run
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > LIMIT_CYCLES) begin
         $display("tb_top NOT OK");
         $finish;
      end
   end

   // Receiver: long holds on request, random stall bursts and free-flowing stretches, no stalls when quiet
   always @(posedge clock) begin
      if (reset) begin
         rsp_stall  <= 1'b0;
         stall_left <= 0;
         flow_left  <= 0;
      end else if (hold_done < hold_total) begin
         rsp_stall <= 1'b1;
         hold_done <= hold_done + 1;
      end else if (quiet) begin
         rsp_stall <= 1'b0;
      end else if (stall_left > 0) begin
         rsp_stall  <= 1'b1;
         stall_left <= stall_left - 1;
      end else if (flow_left > 0) begin
         rsp_stall <= 1'b0;
         flow_left <= flow_left - 1;
      end else begin
         rsp_stall  <= 1'b1;
         stall_left <= $urandom_range(0, 13);
         flow_left  <= ($urandom_range(0, 3) == 0) ? $urandom_range(40, 150)
                                                   : $urandom_range(1, 20);
      end
   end

   task automatic check_field(input string name, input logic [31:0] want,
                              input logic [31:0] got);
      if (want !== got) begin
         err_count++;
         $display("%0t: %s expected %0h actual %0h", $time, name, want, got);
      end
   endtask

   // Compare each accepted response with the oldest predicted chain step
   always @(posedge clock) begin
      chain_step_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (chain_steps_due.size() == 0) begin
            err_count++;
            $display("%0t: response expected none actual cluster %0h next %0h",
                     $time, rsp_cluster, rsp_next_cluster);
         end else begin
            want = chain_steps_due.pop_front();
            check_field("cluster", 32'(want.cluster), 32'(rsp_cluster));
            check_field("sector_lba", want.sector_lba, rsp_sector_lba);
            check_field("next_cluster", 32'(want.next_cluster), 32'(rsp_next_cluster));
            check_field("chain_end", 32'(want.chain_end), 32'(rsp_chain_end));
            check_field("last", 32'(want.last), 32'(rsp_last));
         end
      end
   end

   // 12-bit entry packed at byte cluster*3/2 of the mirror
   function automatic logic [ENTRY_W-1:0] fat_entry(input logic [ENTRY_W-1:0] c);
      int          idx;
      logic [15:0] pair;
      idx  = (int'(c) * 3) / 2;
      pair = {fat_mirror[(idx + 1) % TABLE_SIZE], fat_mirror[idx % TABLE_SIZE]};
      return c[0] ? pair[15:4] : pair[11:0];
   endfunction

   // True when a walk from start reads only bytes that were loaded
   function automatic bit chain_defined(input logic [ENTRY_W-1:0] start);
      logic [ENTRY_W-1:0] c;
      int                 idx;
      c = start;
      for (int n = 0; n < RUN_LIMIT; n++) begin
         idx = (int'(c) * 3) / 2;
         if (!byte_loaded[idx % TABLE_SIZE] || !byte_loaded[(idx + 1) % TABLE_SIZE])
            return 1'b0;
         c = fat_entry(c);
         if (c >= END_MARK)
            return 1'b1;
      end
      return 1'b1;
   endfunction

   // Follow the chain through the mirror and queue every step it produces
   task automatic follow_chain(input logic [ENTRY_W-1:0] start,
                               output logic [ENTRY_W-1:0] tail, output bit limited);
      logic [ENTRY_W-1:0] c;
      chain_step_type     step;
      int                 n;
      c = start;
      n = 0;
      do begin
         n++;
         step.cluster      = c;
         step.sector_lba   = base_q + (32'(c) - 32'd2) * 32'(spc_q);
         step.next_cluster = fat_entry(c);
         step.chain_end    = step.next_cluster >= END_MARK;
         step.last         = step.chain_end || n >= RUN_LIMIT;
         chain_steps_due.push_back(step);
         c = step.next_cluster;
      end while (!step.last);
      tail    = c;
      limited = !step.chain_end;
   endtask

   // Offer one request, with an optional random gap first; leave valid high
   task automatic send_request(input logic kind, input logic [LOAD_AW-1:0] addr,
                               input logic [BYTE_W-1:0] data,
                               input logic [ENTRY_W-1:0] start);
      int gap;
      if (!quiet && $urandom_range(0, 3) == 0) begin
         req_valid <= 1'b0;
         gap = $urandom_range(1, 14);
         repeat (gap) @(posedge clock);
      end
      req_valid         <= 1'b1;
      req_type          <= kind;
      req_table_addr    <= addr;
      req_table_byte    <= data;
      req_start_cluster <= start;
      do @(posedge clock); while (req_stall);
      item_count++;
   endtask

   task automatic load_byte(input int addr, input logic [BYTE_W-1:0] data);
      send_request(REQ_LOAD, addr[LOAD_AW-1:0], data, ENTRY_W'($urandom));
      fat_mirror[addr % TABLE_SIZE]  = data;
      byte_loaded[addr % TABLE_SIZE] = 1'b1;
   endtask

   // Rewrite the two bytes holding one entry, keeping the neighbor's nibble
   task automatic set_entry(input logic [ENTRY_W-1:0] c, input logic [ENTRY_W-1:0] val);
      int          idx;
      logic [7:0]  lo;
      logic [7:0]  hi;
      idx = (int'(c) * 3) / 2;
      lo  = fat_mirror[idx];
      hi  = fat_mirror[idx + 1];
      if (c[0]) begin
         lo[7:4] = val[3:0];
         hi      = val[11:4];
      end else begin
         lo      = val[7:0];
         hi[3:0] = val[11:8];
      end
      load_byte(idx, lo);
      load_byte(idx + 1, hi);
   endtask

   // Walk from start if defined; resume after a run limit up to max_resumes times
   task automatic walk_chain(input logic [ENTRY_W-1:0] start, input int max_resumes);
      logic [ENTRY_W-1:0] at;
      logic [ENTRY_W-1:0] tail;
      bit                 limited;
      int                 resumes;
      at      = start;
      resumes = 0;
      while (chain_defined(at)) begin
         send_request(REQ_WALK, LOAD_AW'($urandom), BYTE_W'($urandom), at);
         follow_chain(at, tail, limited);
         if (!limited || resumes >= max_resumes)
            break;
         at = tail;
         resumes++;
      end
   endtask

   // Build a short chain with random content, then walk it
   task automatic add_chain();
      logic [ENTRY_W-1:0] nodes [$];
      logic [ENTRY_W-1:0] c;
      logic [ENTRY_W-1:0] tail;
      int                 len;
      bit                 packed_run;
      len        = $urandom_range(1, 6);
      c          = ENTRY_W'($urandom);
      packed_run = $urandom_range(0, 1);
      for (int i = 0; i < len; i++)
         nodes.push_back(packed_run ? c + ENTRY_W'(i) : ENTRY_W'($urandom));
      case ($urandom_range(0, 5))
         0, 1, 2: tail = END_MARK + ENTRY_W'($urandom_range(0, 7));
         3, 4:    tail = nodes[$urandom_range(0, len - 1)];
         default: begin
            // free, reserved or bad entry, followed like any other
            case ($urandom_range(0, 2))
               0:       tail = 12'h000;
               1:       tail = 12'h001;
               default: tail = 12'hFF7;
            endcase
         end
      endcase
      for (int i = 0; i < len; i++)
         set_entry(nodes[i], (i < len - 1) ? nodes[i + 1] : tail);
      chain_heads.push_back(nodes[0]);
      walk_chain(nodes[0], $urandom_range(0, 2));
   endtask

   // Let every predicted step arrive, then let a last load settle
   task automatic drain(input int settle);
      req_valid <= 1'b0;
      while (chain_steps_due.size() != 0) @(posedge clock);
      repeat (settle) @(posedge clock);
   endtask

   // Write one register; leave valid high so back-to-back writes stay clean
   task automatic write_csr(input logic [CSR_IDX_W-1:0] idx, input logic [LBA_W-1:0] data);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      do @(posedge clock); while (!csr_ready);
      if (idx == CSR_DATA_BASE)
         base_q = data;
      else if (idx == CSR_SPC)
         spc_q = data[SPC_W-1:0];
   endtask

   task automatic program_registers(input logic [LBA_W-1:0] base,
                                    input logic [SPC_W-1:0] spc);
      drain(LOAD_SETTLE);
      write_csr(CSR_DATA_BASE, base);
      write_csr(CSR_SPC, 32'(spc));
      write_csr($urandom_range(0, 1) ? CSR_SPARE_LO : CSR_SPARE_HI, $urandom);
      csr_valid <= 1'b0;
   endtask

   // Reset values of the registers
   task automatic test_reset_registers();
      set_entry(12'd2, 12'hFFF);
      walk_chain(12'd2, 0);
   endtask

   // Clusters 0, 1 and 4095, lowest end marker, bad and free entries, address extremes
   task automatic test_boundary_clusters();
      program_registers(32'h0000_1000, 8'd4);
      set_entry(12'd0, 12'd1);
      set_entry(12'd1, 12'hFFF);
      walk_chain(12'd0, 0);
      set_entry(12'hFFF, END_MARK);
      walk_chain(12'hFFF, 0);
      set_entry(12'd5, 12'hFF7);
      set_entry(12'hFF7, 12'h000);
      walk_chain(12'd5, 0);
      load_byte(TABLE_SIZE - 1, 8'hFF);
      load_byte(TABLE_SIZE - 2, 8'h00);
   endtask

   // Self loop hits the run limit; resume from the final next cluster
   task automatic test_run_limit();
      set_entry(12'd7, 12'd7);
      walk_chain(12'd7, 1);
   endtask

   // Register extremes, zero and oversized sectors per cluster
   task automatic test_register_extremes();
      program_registers(32'hFFFF_FFFF, 8'd128);
      walk_chain(12'd5, 0);
      program_registers(32'h0000_0000, 8'd0);
      walk_chain(12'd5, 0);
      program_registers($urandom, 8'd255);
      walk_chain(12'd5, 0);
      program_registers(32'h8000_0000, 8'd1);
      walk_chain(12'd5, 0);
      program_registers(32'h0000_0000, 8'd1);
      walk_chain(12'd5, 0);
   endtask

   // Mostly well-formed chains, some noise loads and stray walks, new settings per phase
   task automatic test_random_chains();
      int               phase_mark;
      logic [LBA_W-1:0] base;
      logic [SPC_W-1:0] spc;
      phase_mark = item_count;
      while (item_count < RANDOM_END) begin
         if (item_count - phase_mark >= PHASE_ITEMS) begin
            case ($urandom_range(0, 4))
               0:       base = 32'h0000_0000;
               1:       base = 32'hFFFF_FFFF;
               default: base = $urandom;
            endcase
            case ($urandom_range(0, 5))
               0:       spc = 8'd1;
               1:       spc = 8'd128;
               2:       spc = 8'd0;
               default: spc = SPC_W'($urandom_range(1, 128));
            endcase
            program_registers(base, spc);
            phase_mark = item_count;
         end
         case ($urandom_range(0, 9))
            0, 1, 2, 3, 4: add_chain();
            5, 6: begin
               if (chain_heads.size() != 0)
                  walk_chain(chain_heads[$urandom_range(0, chain_heads.size() - 1)],
                             $urandom_range(0, 2));
            end
            7, 8: load_byte($urandom_range(0, TABLE_SIZE - 1), BYTE_W'($urandom));
            default: walk_chain(ENTRY_W'($urandom), 0);
         endcase
      end
   endtask

   // Hold the receiver off while the sender keeps offering requests
   task automatic test_backpressure();
      hold_total <= hold_total + LONG_HOLD;
      repeat (4) add_chain();
      walk_chain(12'd7, 0);
   endtask

   // Final stretch with no idling on either side
   task automatic test_quiet_tail();
      int built;
      quiet <= 1'b1;
      built = 0;
      while (item_count < ITEM_TARGET || built < 3) begin
         add_chain();
         built++;
      end
   endtask

   initial begin
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_reset_registers();
      test_boundary_clusters();
      test_run_limit();
      test_register_extremes();
      test_random_chains();
      test_backpressure();
      test_quiet_tail();
      drain(FINAL_SETTLE);
      if (err_count == 0)
         $display("tb_top OK");
      else
         $display("tb_top NOT OK");
      $finish;
   end

endmodule
